/* rtl/plcm_pkg.sv */
// Shared types, widths, fixed coefficient tables and arithmetic helpers
// for the pigment latent colour mixer. No dependencies.
package plcm_pkg;

    // Field and datapath widths
    localparam int AMT_W  = 18;   // signed Q2.16 input concentration
    localparam int CW     = 17;   // clamped concentration, 0..65536
    localparam int TW     = 19;   // sum of three clamped concentrations
    localparam int WW     = 17;   // weight, 0..65536
    localparam int LW     = 24;   // Q4.20 coefficient
    localparam int ZW     = 27;   // signed value with 24 fraction bits
    localparam int RW     = 36;   // divider remainder
    localparam int NDIV   = 17;   // quotient bits, one per divider stage
    localparam int BLW    = 44;   // latent blend accumulator
    localparam int PW     = 56;   // polynomial accumulator
    localparam int LVL_W  = 16;   // output level
    localparam int NLAT   = 7;
    localparam int NMON   = 20;
    localparam int ONE16  = 65536;

    // Four weights: white, red, blue, yellow from the lowest lane up
    typedef logic [3:0][WW-1:0] wvec_t;

    // Payload of one divider stage
    typedef struct packed {
        logic                 ovf;
        logic [TW-1:0]        total;
        logic [2:0][CW-1:0]   amt;
        logic [2:0][RW-1:0]   rem;
        logic [2:0][NDIV-1:0] quo;
    } div_stage_t;

    // Decimal (scaled by 1e8) to Q4.20, rounded to nearest, ties away from zero
    function automatic longint qp(input longint n);
        return (n * 64'sd1048576 + 64'sd50000000) / 64'sd100000000;
    endfunction

    function automatic longint qn(input longint n);
        return -qp(n);
    endfunction

    // Latent vectors of white, red, blue and yellow
    localparam logic signed [LW-1:0] LATENT [4][NLAT] = '{
        '{24'sd0, 24'sd0, 24'sd0, LW'(qp(100000000)), LW'(qp(481862)), LW'(qp(21851)),
          LW'(qp(295198))},
        '{24'sd0, LW'(qp(33960806)), LW'(qp(65860828)), LW'(qp(178365)), LW'(qp(8873356)),
          LW'(qn(1747544)), LW'(qn(6755477))},
        '{LW'(qp(86413725)), LW'(qp(441961)), LW'(qp(2987264)), LW'(qp(10157050)),
          LW'(qn(5379499)), LW'(qn(1226009)), LW'(qp(350272))},
        '{LW'(qp(392157)), LW'(qp(85950980)), 24'sd0, LW'(qp(13656863)), LW'(qp(3300247)),
          LW'(qp(10249173)), LW'(qn(8066935))}
    };

    // Cubic coefficients, one row per monomial, columns R, G, B
    localparam logic signed [LW-1:0] POLY [NMON][3] = '{
        '{LW'(qp(7717053)),   LW'(qp(2826978)),   LW'(qp(24832992))},
        '{LW'(qp(95912302)),  LW'(qp(80256528)),  LW'(qp(3561839))},
        '{LW'(qp(74683774)),  LW'(qp(4868586)),   24'sd0},
        '{LW'(qp(99518138)),  LW'(qp(99978149)),  LW'(qp(99704802))},
        '{LW'(qp(4819146)),   LW'(qp(83363781)),  LW'(qp(32515377))},
        '{LW'(qn(68146950)),  LW'(qp(146107803)), LW'(qp(106980936))},
        '{LW'(qp(27058419)),  LW'(qn(15324870)),  LW'(qp(198735057))},
        '{LW'(qp(80478189)),  LW'(qp(67093710)),  LW'(qp(18424500))},
        '{LW'(qn(35031003)),  LW'(qp(137855826)), LW'(qp(368865000))},
        '{LW'(qp(105128046)), LW'(qp(197815239)), LW'(qp(282989073))},
        '{LW'(qp(321607125)), LW'(qp(81270228)),  LW'(qp(103384539))},
        '{LW'(qp(278893374)), LW'(qp(41565549)),  LW'(qn(4487295))},
        '{LW'(qp(302162577)), LW'(qp(255374103)), LW'(qp(32766114))},
        '{LW'(qp(295124691)), LW'(qp(281201112)), LW'(qp(117578442))},
        '{LW'(qp(282677043)), LW'(qp(79933038)),  LW'(qp(181715262))},
        '{LW'(qp(299691099)), LW'(qp(122593053)), LW'(qp(180653661))},
        '{LW'(qp(187394106)), LW'(qp(205027182)), LW'(qn(29835996))},
        '{LW'(qp(256609566)), LW'(qp(703428198)), LW'(qp(62575374))},
        '{LW'(qp(408329484)), LW'(qn(140408358)), LW'(qp(214995522))},
        '{LW'(qp(600078678)), LW'(qp(255552042)), LW'(qp(190739502))}
    };

    localparam logic signed [2*ZW-1:0] RND24 = (2*ZW)'(64'sd8388608);

    // Clamp a signed Q2.16 concentration to 0..1
    function automatic logic [CW-1:0] clamp_amount(input logic signed [AMT_W-1:0] v);
        logic [CW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > AMT_W'(ONE16))
            r = CW'(ONE16);
        else
            r = v[CW-1:0];
        return r;
    endfunction

    // Product of two 24-fraction-bit values, rounded back to 24 fraction bits
    function automatic logic signed [ZW-1:0] mul24(input logic signed [ZW-1:0] a,
                                                   input logic signed [ZW-1:0] b);
        logic signed [2*ZW-1:0] p;
        p = (2*ZW)'(a) * (2*ZW)'(b);
        p = p + RND24;
        return ZW'(p >>> 24);
    endfunction

endpackage

/* rtl/pigment_latent_color_mix.sv */
// Pigment latent colour mixer: red, blue and yellow concentrations in, mixed
// RGB levels out. One transfer is accepted per clock while the queue has room and
// results leave at one per clock while the output is ready, after one clamp stage,
// a 17-stage divider pipeline that normalises on pigment overflow, the weight queue
// and a 5-stage evaluation pipeline, the divider being the longest. Both halves stall
// independently via the queue. Depends on plcm_pkg, plcm_front, plcm_queue, plcm_back.
module pigment_latent_color_mix #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [17:0] red_amount, [35:18] blue_amount, [53:36] yellow_amount, [55:54] zero
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] red_level, [31:16] green_level, [47:32] blue_level
    output logic [47:0] m_axis_tdata
);
    import plcm_pkg::*;

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    wvec_t push_data;
    wvec_t q_data;

    plcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata[3*AMT_W-1:0]),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    plcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_data),
        .pop   (pop),
        .dout  (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    plcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

/* rtl/plcm_front.sv */
// Front end: clamps concentrations, finds the white share and, on pigment
// overflow, normalises by the sum in a 17-stage restoring divider. Uses plcm_pkg.
module plcm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3*plcm_pkg::AMT_W-1:0] in_data,
    output logic                 push,
    output plcm_pkg::wvec_t      push_data,
    input  logic                 q_full
);
    import plcm_pkg::*;

    logic                 adv;
    logic [NDIV:0]        vld_reg;
    div_stage_t           stg_reg [NDIV+1];
    div_stage_t           stg0_next;
    logic [2:0][CW-1:0]   amt_c;
    logic [TW-1:0]        tot_c;

    // Whole front moves together whenever the queue has room
    assign adv      = !q_full;
    assign in_ready = adv;

    // Clamp and classify
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            amt_c[j] = clamp_amount(in_data[j*AMT_W +: AMT_W]);
        end
        tot_c           = TW'(amt_c[0]) + TW'(amt_c[1]) + TW'(amt_c[2]);
        stg0_next.ovf   = tot_c > TW'(ONE16);
        stg0_next.total = tot_c;
        stg0_next.amt   = amt_c;
        stg0_next.quo   = '0;
        for (int j = 0; j < 3; j++)
        begin
            // dividend: c * 65536 + total / 2
            stg0_next.rem[j] = {RW'(amt_c[j]) << 16} + RW'(tot_c >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg[0] <= stg0_next;
        end
    end

    // Divider stages, one quotient bit each, three lanes
    for (genvar s = 0; s < NDIV; s++)
    begin : g_div
        div_stage_t    nxt;
        logic [RW-1:0] dsh;

        always_comb
        begin
            nxt = stg_reg[s];
            dsh = RW'(stg_reg[s].total) << (NDIV - 1 - s);
            for (int j = 0; j < 3; j++)
            begin
                if (stg_reg[s].rem[j] >= dsh)
                begin
                    nxt.rem[j]             = stg_reg[s].rem[j] - dsh;
                    nxt.quo[j][NDIV-1-s]   = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stg_reg[s+1] <= nxt;
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NDIV-1:0], in_valid};
        end
    end

    // Weight selection
    always_comb
    begin
        if (stg_reg[NDIV].ovf)
        begin
            push_data[0] = '0;
            for (int j = 0; j < 3; j++)
            begin
                push_data[j+1] = stg_reg[NDIV].quo[j];
            end
        end
        else
        begin
            push_data[0] = WW'(TW'(ONE16) - stg_reg[NDIV].total);
            for (int j = 0; j < 3; j++)
            begin
                push_data[j+1] = stg_reg[NDIV].amt[j];
            end
        end
    end

    assign push = vld_reg[NDIV] && adv;

`ifndef SYNTHESIS
    logic [TW-1:0] wsum;
    assign wsum = TW'(push_data[0]) + TW'(push_data[1]) + TW'(push_data[2])
                + TW'(push_data[3]);

    a_mass_exact: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NDIV] && !stg_reg[NDIV].ovf |-> wsum == TW'(ONE16))
        else $error("weights do not sum to one");

    a_mass_norm: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NDIV] && stg_reg[NDIV].ovf |->
            push_data[0] == '0 && wsum >= TW'(ONE16 - 2) && wsum <= TW'(ONE16 + 2))
        else $error("normalised weights off unit mass");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NDIV] && q_full |=> vld_reg[NDIV] && $stable(push_data))
        else $error("front item lost while queue full");
`endif

endmodule

/* rtl/plcm_queue.sv */
// Small FIFO of weight vectors between front and back ends. Uses plcm_pkg.
// Register-based; depth set by parameter.
module plcm_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  plcm_pkg::wvec_t din,
    input  logic            pop,
    output plcm_pkg::wvec_t dout,
    output logic            full,
    output logic            empty
);
    import plcm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wvec_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = cnt_reg == CNT_W'(DEPTH);
    assign empty = cnt_reg == '0;
    assign dout  = mem_reg[rd_reg];

    // Pointer and count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

endmodule

/* rtl/plcm_back.sv */
// Back end: latent blend, cubic monomials, polynomial sums and output
// clamping in a five-stage pipeline ending in the output register. Uses plcm_pkg.
module plcm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  plcm_pkg::wvec_t      q_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3*plcm_pkg::LVL_W-1:0] out_data
);
    import plcm_pkg::*;

    logic                    adv;
    logic [4:0]              vld_reg;
    logic signed [ZW-1:0]    z_reg   [NLAT];
    logic signed [ZW-1:0]    z_next  [NLAT];
    logic signed [ZW-1:0]    v2_reg  [4];
    logic signed [ZW-1:0]    sq_reg  [7];
    logic signed [ZW-1:0]    r2_reg  [3];
    logic signed [ZW-1:0]    m_reg   [NMON];
    logic signed [ZW-1:0]    m_next  [NMON];
    logic signed [ZW-1:0]    r3_reg  [3];
    logic signed [PW-1:0]    lo_reg  [3];
    logic signed [PW-1:0]    hi_reg  [3];
    logic signed [PW-1:0]    lo_next [3];
    logic signed [PW-1:0]    hi_next [3];
    logic signed [ZW-1:0]    r4_reg  [3];
    logic [2:0][LVL_W-1:0]   lvl_reg;
    logic [2:0][LVL_W-1:0]   lvl_next;

    assign adv       = !vld_reg[4] || out_ready;
    assign pop       = adv && !q_empty;
    assign out_valid = vld_reg[4];
    assign out_data  = lvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], !q_empty};
        end
    end

    // Stage 1: blend latent vectors
    always_comb
    begin
        logic signed [BLW-1:0] acc;
        for (int i = 0; i < NLAT; i++)
        begin
            acc = '0;
            for (int k = 0; k < 4; k++)
            begin
                acc = acc + BLW'($signed({1'b0, q_data[k]})) * BLW'(LATENT[k][i]);
            end
            acc       = acc + BLW'(2048);
            z_next[i] = ZW'(acc >>> 12);
        end
    end

    // Stage 3 inputs: cubic monomials from squares and cross terms
    // squares: aa bb cc dd, cross: ab ac bc
    always_comb
    begin
        m_next[0]  = mul24(v2_reg[0], sq_reg[0]);
        m_next[1]  = mul24(v2_reg[1], sq_reg[1]);
        m_next[2]  = mul24(v2_reg[2], sq_reg[2]);
        m_next[3]  = mul24(v2_reg[3], sq_reg[3]);
        m_next[4]  = mul24(sq_reg[0], v2_reg[1]);
        m_next[5]  = mul24(sq_reg[4], v2_reg[1]);
        m_next[6]  = mul24(sq_reg[0], v2_reg[2]);
        m_next[7]  = mul24(sq_reg[5], v2_reg[2]);
        m_next[8]  = mul24(sq_reg[0], v2_reg[3]);
        m_next[9]  = mul24(v2_reg[0], sq_reg[3]);
        m_next[10] = mul24(sq_reg[1], v2_reg[2]);
        m_next[11] = mul24(v2_reg[1], sq_reg[2]);
        m_next[12] = mul24(sq_reg[1], v2_reg[3]);
        m_next[13] = mul24(v2_reg[1], sq_reg[3]);
        m_next[14] = mul24(sq_reg[2], v2_reg[3]);
        m_next[15] = mul24(v2_reg[2], sq_reg[3]);
        m_next[16] = mul24(sq_reg[4], v2_reg[2]);
        m_next[17] = mul24(sq_reg[4], v2_reg[3]);
        m_next[18] = mul24(sq_reg[5], v2_reg[3]);
        m_next[19] = mul24(sq_reg[6], v2_reg[3]);
    end

    // Stage 4 inputs: coefficient sums, split in two halves
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_next[k] = '0;
            hi_next[k] = '0;
            for (int i = 0; i < NMON / 2; i++)
            begin
                lo_next[k] = lo_next[k] + PW'(POLY[i][k]) * PW'(m_reg[i]);
                hi_next[k] = hi_next[k]
                           + PW'(POLY[i + NMON / 2][k]) * PW'(m_reg[i + NMON / 2]);
            end
        end
    end

    // Stage 5 inputs: add residual, round to 16 bits and clamp
    always_comb
    begin
        logic signed [PW-1:0] acc;
        logic signed [PW-1:0] ch;
        for (int k = 0; k < 3; k++)
        begin
            acc = lo_reg[k] + hi_reg[k] + PW'(524288);
            ch  = (acc >>> 20) + PW'(r4_reg[k]) + PW'(128);
            ch  = ch >>> 8;
            if (ch < 0)
                lvl_next[k] = '0;
            else if (ch > PW'(65535))
                lvl_next[k] = '1;
            else
                lvl_next[k] = ch[LVL_W-1:0];
        end
    end

    // Pipeline registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_reg <= z_next;
            for (int i = 0; i < 4; i++)
            begin
                v2_reg[i] <= z_reg[i];
            end
            sq_reg[0] <= mul24(z_reg[0], z_reg[0]);
            sq_reg[1] <= mul24(z_reg[1], z_reg[1]);
            sq_reg[2] <= mul24(z_reg[2], z_reg[2]);
            sq_reg[3] <= mul24(z_reg[3], z_reg[3]);
            sq_reg[4] <= mul24(z_reg[0], z_reg[1]);
            sq_reg[5] <= mul24(z_reg[0], z_reg[2]);
            sq_reg[6] <= mul24(z_reg[1], z_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                r2_reg[k] <= z_reg[4 + k];
                r3_reg[k] <= r2_reg[k];
                r4_reg[k] <= r3_reg[k];
            end
            m_reg   <= m_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            lvl_reg <= lvl_next;
        end
    end

endmodule
